/* rtl/html_codepoint_to_utf8_unit_defines.svh */
// Assertion macros for the HTML code point to UTF-8 unit.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef HTML_CODEPOINT_TO_UTF8_UNIT_DEFINES_SVH
`define HTML_CODEPOINT_TO_UTF8_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HCU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define HCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/hcu_pkg.sv */
// Package for the HTML code point to UTF-8 unit: result type, code constants
// and the Windows-1252 remap table. No dependencies.
`default_nettype none

package hcu_pkg;

	localparam logic [31:0] CP_CR     = 32'h0000_000D;
	localparam logic [31:0] CP_MAX    = 32'h0010_FFFF;
	localparam logic [31:0] CP_SUR_LO = 32'h0000_D800;
	localparam logic [31:0] CP_SUR_HI = 32'h0000_DFFF;
	localparam logic [31:0] CP_C1_LO  = 32'h0000_0080;
	localparam logic [31:0] CP_C1_HI  = 32'h0000_009F;
	localparam logic [31:0] CP_NC_LO  = 32'h0000_FDD0;
	localparam logic [31:0] CP_NC_HI  = 32'h0000_FDEF;

	localparam logic [7:0] ASCII_BSLASH = 8'h5C;
	localparam logic [7:0] ASCII_R      = 8'h72;
	localparam logic [7:0] ASCII_X      = 8'h78;

	// bytes[0] is the first byte on the wire
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
	} result_t;

	function automatic result_t mk3(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
			logic [7:0] b3, logic [2:0] n);
		result_t r;
		r.bytes = {b3, b2, b1, b0};
		r.count = n;
		return r;
	endfunction

	// Windows-1252 remap of 0x80..0x9F; undefined slots spell out \xNN
	function automatic result_t cp1252_lookup(logic [4:0] idx);
		result_t r;
		case (idx)
			5'd0:  r = mk3(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd3);
			5'd1:  r = mk3(ASCII_BSLASH, ASCII_X, 8'h38, 8'h31, 3'd4);
			5'd2:  r = mk3(8'hE2, 8'h80, 8'h9A, 8'h00, 3'd3);
			5'd3:  r = mk3(8'hC6, 8'h92, 8'h00, 8'h00, 3'd2);
			5'd4:  r = mk3(8'hE2, 8'h80, 8'h9E, 8'h00, 3'd3);
			5'd5:  r = mk3(8'hE2, 8'h80, 8'hA6, 8'h00, 3'd3);
			5'd6:  r = mk3(8'hE2, 8'h80, 8'hA0, 8'h00, 3'd3);
			5'd7:  r = mk3(8'hE2, 8'h80, 8'hA1, 8'h00, 3'd3);
			5'd8:  r = mk3(8'hCB, 8'h86, 8'h00, 8'h00, 3'd2);
			5'd9:  r = mk3(8'hE2, 8'h80, 8'hB0, 8'h00, 3'd3);
			5'd10: r = mk3(8'hC5, 8'hA0, 8'h00, 8'h00, 3'd2);
			5'd11: r = mk3(8'hE2, 8'h80, 8'hB9, 8'h00, 3'd3);
			5'd12: r = mk3(8'hC5, 8'h92, 8'h00, 8'h00, 3'd2);
			5'd13: r = mk3(ASCII_BSLASH, ASCII_X, 8'h38, 8'h64, 3'd4);
			5'd14: r = mk3(8'hC5, 8'hBD, 8'h00, 8'h00, 3'd2);
			5'd15: r = mk3(ASCII_BSLASH, ASCII_X, 8'h38, 8'h66, 3'd4);
			5'd16: r = mk3(ASCII_BSLASH, ASCII_X, 8'h39, 8'h30, 3'd4);
			5'd17: r = mk3(8'hE2, 8'h80, 8'h98, 8'h00, 3'd3);
			5'd18: r = mk3(8'hE2, 8'h80, 8'h99, 8'h00, 3'd3);
			5'd19: r = mk3(8'hE2, 8'h80, 8'h9C, 8'h00, 3'd3);
			5'd20: r = mk3(8'hE2, 8'h80, 8'h9D, 8'h00, 3'd3);
			5'd21: r = mk3(8'hE2, 8'h80, 8'hA2, 8'h00, 3'd3);
			5'd22: r = mk3(8'hE2, 8'h80, 8'h93, 8'h00, 3'd3);
			5'd23: r = mk3(8'hE2, 8'h80, 8'h94, 8'h00, 3'd3);
			5'd24: r = mk3(8'hCB, 8'h9C, 8'h00, 8'h00, 3'd2);
			5'd25: r = mk3(8'hE2, 8'h84, 8'hA2, 8'h00, 3'd3);
			5'd26: r = mk3(8'hC5, 8'hA1, 8'h00, 8'h00, 3'd2);
			5'd27: r = mk3(8'hE2, 8'h80, 8'hBA, 8'h00, 3'd3);
			5'd28: r = mk3(8'hC5, 8'h93, 8'h00, 8'h00, 3'd2);
			5'd29: r = mk3(ASCII_BSLASH, ASCII_X, 8'h39, 8'h64, 3'd4);
			5'd30: r = mk3(8'hC5, 8'hBE, 8'h00, 8'h00, 3'd2);
			5'd31: r = mk3(8'hC5, 8'hB8, 8'h00, 8'h00, 3'd2);
			default: r = mk3(8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/hcu_encode.sv */
// Combinational mapping of one code point to its output bytes and count.
// Depends on hcu_pkg.
`default_nettype none

module hcu_encode (
	input  logic [31:0]     code_point,
	output hcu_pkg::result_t res
);
	import hcu_pkg::*;

	logic is_repl;
	logic is_c1;
	logic is_drop;
	logic [4:0] c1_idx;

	always_comb begin
		is_repl = (code_point == 32'd0) || (code_point > CP_MAX) ||
			((code_point >= CP_SUR_LO) && (code_point <= CP_SUR_HI));
		is_c1   = (code_point >= CP_C1_LO) && (code_point <= CP_C1_HI);
		c1_idx  = code_point[4:0];
		// only consulted once out-of-range values are gone
		is_drop = (code_point inside {[32'h01:32'h08], 32'h0B, [32'h0E:32'h1F], 32'h7F}) ||
			((code_point >= CP_NC_LO) && (code_point <= CP_NC_HI)) ||
			(code_point[15:1] == 15'h7FFF);
	end

	always_comb begin
		res = mk3(8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
		if (code_point == CP_CR) begin
			res = mk3(ASCII_BSLASH, ASCII_R, 8'h00, 8'h00, 3'd2);
		end else if (is_repl) begin
			res = mk3(8'hEF, 8'hBF, 8'hBD, 8'h00, 3'd3);
		end else if (is_c1) begin
			res = cp1252_lookup(c1_idx);
		end else if (is_drop) begin
			res = mk3(8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
		end else if (code_point <= 32'h7F) begin
			res = mk3(code_point[7:0], 8'h00, 8'h00, 8'h00, 3'd1);
		end else if (code_point <= 32'h7FF) begin
			res = mk3({3'b110, code_point[10:6]}, {2'b10, code_point[5:0]},
				8'h00, 8'h00, 3'd2);
		end else if (code_point <= 32'hFFFF) begin
			res = mk3({4'b1110, code_point[15:12]}, {2'b10, code_point[11:6]},
				{2'b10, code_point[5:0]}, 8'h00, 3'd3);
		end else begin
			res = mk3({5'b11110, code_point[20:18]}, {2'b10, code_point[17:12]},
				{2'b10, code_point[11:6]}, {2'b10, code_point[5:0]}, 3'd4);
		end
	end

endmodule

`default_nettype wire

/* rtl/html_codepoint_to_utf8_unit.sv */
// Top level of the HTML code point to UTF-8 unit: input register, encoder,
// result register. Depends on hcu_pkg and hcu_encode.
//
// Usage:
//   Input channel: in_valid / in_ready carry one 32-bit code_point per
//   transfer. Output channel: out_valid / out_ready carry out_byte0..3 and
//   byte_count (0..4; 0 means the code point was dropped, unused bytes are 0).
//   Every input transfer yields exactly one output transfer, in order.
//   Path: a code point that is taken is held in the input register, goes
//   through the encoder and is held in the result register, from which it
//   is presented on the output channel.
//   Throughput: one code point per cycle while out_ready is high, set by both
//   pipeline registers; the encoder is pure compare-and-table logic, no loop.
//   Stall: when out_ready is low the result register holds; the input
//   register can still take one more item, so in_ready only falls once both
//   stages are full and the receiver is stalled.
//   Reset: arst_n low clears both valid flags at once; items in flight are
//   discarded, none is invented, and there is no configuration.
`default_nettype none

module html_codepoint_to_utf8_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] code_point,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte0,
	output logic [7:0]  out_byte1,
	output logic [7:0]  out_byte2,
	output logic [7:0]  out_byte3,
	output logic [2:0]  byte_count
);
	import hcu_pkg::*;

	logic        valid_s1;
	logic [31:0] cp_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     enc_res;
	logic        s2_load;
	logic        s1_load;

	// stage 2 frees up when empty or when its result leaves this cycle
	assign s2_load  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || s2_load;
	assign s1_load  = in_ready;

	hcu_encode u_encode (
		.code_point (cp_s1),
		.res        (enc_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= in_valid;
			end
			if (s2_load) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (s1_load && in_valid) begin
			cp_s1 <= code_point;
		end
		if (s2_load && valid_s1) begin
			res_s2 <= enc_res;
		end
	end

	assign out_valid  = valid_s2;
	assign out_byte0  = res_s2.bytes[0];
	assign out_byte1  = res_s2.bytes[1];
	assign out_byte2  = res_s2.bytes[2];
	assign out_byte3  = res_s2.bytes[3];
	assign byte_count = res_s2.count;

endmodule

`default_nettype wire

/* rtl/hcu_checker.sv */
// Port-level checker for html_codepoint_to_utf8_unit, bound to the top level.
// Depends on html_codepoint_to_utf8_unit_defines.svh.
`default_nettype none

`include "html_codepoint_to_utf8_unit_defines.svh"

module hcu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte0,
	input logic [7:0]  out_byte1,
	input logic [7:0]  out_byte2,
	input logic [7:0]  out_byte3,
	input logic [2:0]  byte_count
);

	`HCU_ASSERT_NOW(a_count_range, out_valid, byte_count <= 3'd4, "byte_count above 4")

	`HCU_ASSERT_NOW(a_unused_zero, out_valid && byte_count < 3'd4, out_byte3 == 8'h00,
		"unused fourth byte not zero")

	`HCU_ASSERT_NOW(a_cr_escape, out_valid && byte_count == 3'd2 && out_byte0 == 8'h5C,
		out_byte1 == 8'h72, "two-byte escape is not backslash r")

	`HCU_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
		out_valid && $stable(out_byte0) && $stable(out_byte1) && $stable(out_byte2) &&
		$stable(out_byte3) && $stable(byte_count), "stalled result changed")

	// an empty output stage can never block the input side
	`HCU_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "in_ready low with output empty")

endmodule

bind html_codepoint_to_utf8_unit hcu_checker u_hcu_checker (.*);

`default_nettype wire
